// ----- rtl/straight_line_hit_coincidence_assert.svh -----
`ifndef STRAIGHT_LINE_HIT_COINCIDENCE_ASSERT_SVH
`define STRAIGHT_LINE_HIT_COINCIDENCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shlc assertion failed");

// Next-cycle implication, checked outside reset.
`define SHLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shlc assertion failed");

`endif

// ----- rtl/shlc_pkg.sv -----
package shlc_pkg;

    localparam int LAYERS_DEF    = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CH_PER_LAYER  = 24;
    localparam int LOC_COUNT     = 12;
    localparam int LOC_W         = 4;
    localparam int LAYER_W       = 4;
    localparam int CNT_W         = 5;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 24;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 72;

    localparam logic [23:0] MIN_AREA_RST   = 24'd100000;
    localparam logic [15:0] TIME_LOW_RST   = 16'd14400;
    localparam logic [15:0] TIME_HIGH_RST  = 16'd24000;
    localparam logic [2:0]  MIN_LAYERS_RST = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_AREA   = 4'd0,
        REG_TIME_LOW   = 4'd1,
        REG_TIME_HIGH  = 4'd2,
        REG_MIN_LAYERS = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [23:0] min_area;
        logic [15:0] time_low;
        logic [15:0] time_high;
        logic [2:0]  min_layers;
    } cfg_t;

    typedef struct packed {
        logic               is_hit;
        logic               eoe;
        logic [LAYER_W-1:0] layer;
        logic [LOC_W-1:0]   loc;
    } hit_op_t;

    function automatic logic [LAYER_W-1:0] ch_layer(input logic [6:0] ch);
        logic [LAYER_W-1:0] l;
        if (ch >= 7'd120)
            l = 4'd5;
        else if (ch >= 7'd96)
            l = 4'd4;
        else if (ch >= 7'd72)
            l = 4'd3;
        else if (ch >= 7'd48)
            l = 4'd2;
        else if (ch >= 7'd24)
            l = 4'd1;
        else
            l = 4'd0;
        return l;
    endfunction

    function automatic logic [6:0] layer_base(input logic [LAYER_W-1:0] l);
        logic [6:0] b;
        case (l)
            4'd1:    b = 7'd24;
            4'd2:    b = 7'd48;
            4'd3:    b = 7'd72;
            4'd4:    b = 7'd96;
            4'd5:    b = 7'd120;
            default: b = 7'd0;
        endcase
        return b;
    endfunction

    // Column 2 for positions 0..7, 1 for 8..15, 0 for 16..23; row falls with position.
    function automatic logic [LOC_W-1:0] pos_loc(input logic [4:0] p);
        logic [1:0] col;
        logic [1:0] row;
        if (p < 5'd8)
            col = 2'd2;
        else if (p < 5'd16)
            col = 2'd1;
        else
            col = 2'd0;
        row = 2'd3 - p[2:1];
        return {col, row};
    endfunction

endpackage

// ----- rtl/shlc_front.sv -----
module shlc_front #(
    parameter int LAYERS = shlc_pkg::LAYERS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  shlc_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             hit_valid,
    input  logic [6:0]       channel,
    input  logic             pickup_tight,
    input  logic             boards_matched,
    input  logic [7:0]       pulse_index,
    input  logic [15:0]      hit_time,
    input  logic [23:0]      hit_area,
    input  logic             end_of_event,
    output logic             op_valid,
    input  logic             op_ready,
    output shlc_pkg::hit_op_t op
);
    import shlc_pkg::*;

    localparam int CH_LIMIT = CH_PER_LAYER * LAYERS;

    logic               front_valid_reg;
    logic               front_valid_next;
    hit_op_t            op_reg;
    hit_op_t            op_next;
    logic               accept;
    logic               qualified;
    logic [LAYER_W-1:0] layer;
    logic [6:0]         pos_full;

    assign in_ready = !front_valid_reg || op_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        qualified = hit_valid && !pickup_tight && boards_matched
                    && (pulse_index == 8'd0)
                    && (hit_time >= cfg.time_low) && (hit_time <= cfg.time_high)
                    && (hit_area >= cfg.min_area)
                    && ({3'b000, channel} < 10'(CH_LIMIT));
        layer    = ch_layer(channel);
        pos_full = channel - layer_base(layer);
        op_next.is_hit = qualified;
        op_next.eoe    = end_of_event;
        op_next.layer  = layer;
        op_next.loc    = pos_loc(pos_full[4:0]);
    end

    always_comb
    begin
        if (accept)
            front_valid_next = qualified || end_of_event;
        else if (op_ready)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= op_next;
    end

    assign op_valid = front_valid_reg;
    assign op       = op_reg;

endmodule

// ----- rtl/shlc_fifo.sv -----
module shlc_fifo #(
    parameter int DEPTH = shlc_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  shlc_pkg::hit_op_t push_op,
    output logic              pop_valid,
    input  logic              pop_ready,
    output shlc_pkg::hit_op_t pop_op
);
    import shlc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    hit_op_t           store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg < CNT_QW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_op     = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_op;
    end

endmodule

// ----- rtl/shlc_back.sv -----
module shlc_back #(
    parameter int LAYERS = shlc_pkg::LAYERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        min_layers,
    input  logic              op_valid,
    output logic              op_ready,
    input  shlc_pkg::hit_op_t op,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              keep_event,
    output logic [31:0]       passed_count,
    output logic [31:0]       event_count
);
    import shlc_pkg::*;

    logic [LAYERS-1:0] mask_reg [LOC_COUNT];
    logic [LAYERS-1:0] mask_next [LOC_COUNT];
    logic [LAYERS-1:0] merged [LOC_COUNT];
    logic [LAYERS-1:0] hit_bits;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              keep_reg;
    logic              keep_next;
    logic [31:0]       kept_reg;
    logic [31:0]       kept_next;
    logic [31:0]       seen_reg;
    logic [31:0]       seen_next;
    logic              pop;
    logic              close;
    logic              keep_now;

    assign op_ready = !op.eoe || !out_valid_reg || out_ready;
    assign pop      = op_valid && op_ready;
    assign close    = pop && op.eoe;

    always_comb
    begin
        for (int j = 0; j < LAYERS; j++)
            hit_bits[j] = (op.layer == LAYER_W'(j));
        keep_now = 1'b0;
        for (int i = 0; i < LOC_COUNT; i++)
        begin
            merged[i] = mask_reg[i];
            if (op.is_hit && (op.loc == LOC_W'(i)))
                merged[i] = mask_reg[i] | hit_bits;
            if (CNT_W'($countones(merged[i])) >= {2'b00, min_layers})
                keep_now = 1'b1;
            if (close)
                mask_next[i] = '0;
            else if (pop)
                mask_next[i] = merged[i];
            else
                mask_next[i] = mask_reg[i];
        end
    end

    always_comb
    begin
        keep_next = keep_reg;
        kept_next = kept_reg;
        seen_next = seen_reg;
        if (close)
        begin
            keep_next = keep_now;
            seen_next = seen_reg + 32'd1;
            kept_next = kept_reg + {31'd0, keep_now};
        end
        if (close)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOC_COUNT; i++)
                mask_reg[i] <= '0;
            out_valid_reg <= 1'b0;
            keep_reg      <= 1'b0;
            kept_reg      <= '0;
            seen_reg      <= '0;
        end
        else
        begin
            for (int i = 0; i < LOC_COUNT; i++)
                mask_reg[i] <= mask_next[i];
            out_valid_reg <= out_valid_next;
            keep_reg      <= keep_next;
            kept_reg      <= kept_next;
            seen_reg      <= seen_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign keep_event   = keep_reg;
    assign passed_count = kept_reg;
    assign event_count  = seen_reg;

endmodule

// ----- rtl/straight_line_hit_coincidence.sv -----
// Hit coincidence filter for a layered straight-line detector.
// The input stream carries one hit word per transfer: tuser is hit_valid, tlast
// marks the last word of an event, and tdata packs the hit fields. Hits that
// pass the quality cuts set one layer bit at one of twelve detector locations.
// Each tlast word produces exactly one output word with the keep decision and
// the running kept and seen event totals; other words produce nothing.
// The block accepts one input word per cycle when the output is drained.
// A tlast word loads the qualify register when accepted, then enters the
// four-entry queue and then loads the output register, where its output word
// becomes valid; a full queue or a stalled output can hold it in between.
// A stalled output holds its word while hit words keep flowing; once the next
// tlast word waits at the head of the queue, up to four more hit or tlast words
// fill the queue and the qualify register before tready deasserts.
// The cfg channel writes min_area, time_low, time_high and min_layers at
// indexes 0 to 3 and is always ready; other indexes are ignored. Write it only
// while no event is in flight.
// Reset clears the masks, the totals and the pipeline and restores the register
// defaults; the block is ready in the first cycle after reset.
module straight_line_hit_coincidence #(
    parameter int LAYERS = shlc_pkg::LAYERS_DEF,
    parameter int QDEPTH = shlc_pkg::QUEUE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // channel[6:0], pickup_tight[7], boards_matched[8], pulse_index[16:9],
    // hit_time[32:17], hit_area[56:33], zero[63:57]
    input  logic [shlc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // hit_valid[0]
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // keep_event[0], passed_count[32:1], event_count[64:33], zero[71:65]
    output logic [shlc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [shlc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [shlc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import shlc_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    hit_op_t front_op;
    hit_op_t back_op;
    logic    front_valid;
    logic    front_ready;
    logic    back_valid;
    logic    back_ready;
    logic    keep_event;
    logic [31:0] passed_count;
    logic [31:0] event_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_AREA:   cfg_next.min_area   = cfg_data;
                REG_TIME_LOW:   cfg_next.time_low   = cfg_data[15:0];
                REG_TIME_HIGH:  cfg_next.time_high  = cfg_data[15:0];
                REG_MIN_LAYERS: cfg_next.min_layers = cfg_data[2:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_area   <= MIN_AREA_RST;
            cfg_reg.time_low   <= TIME_LOW_RST;
            cfg_reg.time_high  <= TIME_HIGH_RST;
            cfg_reg.min_layers <= MIN_LAYERS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    shlc_front #(
        .LAYERS (LAYERS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .hit_valid      (s_axis_tuser),
        .channel        (s_axis_tdata[6:0]),
        .pickup_tight   (s_axis_tdata[7]),
        .boards_matched (s_axis_tdata[8]),
        .pulse_index    (s_axis_tdata[16:9]),
        .hit_time       (s_axis_tdata[32:17]),
        .hit_area       (s_axis_tdata[56:33]),
        .end_of_event   (s_axis_tlast),
        .op_valid       (front_valid),
        .op_ready       (front_ready),
        .op             (front_op)
    );

    shlc_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_op     (back_op)
    );

    shlc_back #(
        .LAYERS (LAYERS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_layers   (cfg_reg.min_layers),
        .op_valid     (back_valid),
        .op_ready     (back_ready),
        .op           (back_op),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .keep_event   (keep_event),
        .passed_count (passed_count),
        .event_count  (event_count)
    );

    assign m_axis_tdata = {7'd0, event_count, passed_count, keep_event};

endmodule

// ----- rtl/shlc_checker.sv -----
`include "straight_line_hit_coincidence_assert.svh"

module shlc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [shlc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import shlc_pkg::*;

    logic        out_fire;
    logic        out_stall;
    logic [31:0] seen;
    logic [31:0] passed;
    logic [31:0] kept_step;

    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign seen      = m_axis_tdata[64:33];
    assign passed    = m_axis_tdata[32:1];
    assign kept_step = 32'(m_axis_tdata[0]);

    `SHLC_ASSERT_NEXT(a_out_hold_valid, clk, rst_n, out_stall, m_axis_tvalid)

    `SHLC_ASSERT_NEXT(a_out_hold_data, clk, rst_n, out_stall, $stable(m_axis_tdata))

    // Back-to-back results belong to consecutive events.
    `SHLC_ASSERT_NOW(a_seen_step, clk, rst_n, $past(out_fire) && m_axis_tvalid,
                     seen == $past(seen) + 32'd1)

    // The kept total advances only when the new event is kept.
    `SHLC_ASSERT_NOW(a_passed_step, clk, rst_n, $past(out_fire) && m_axis_tvalid,
                     passed == $past(passed) + kept_step)

endmodule

bind straight_line_hit_coincidence shlc_checker u_shlc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
